// ----- src/rwsd_pkg.sv -----
// Package for the rolling window standard deviation block.
// Holds shared widths, reset values and the unit status type.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package rwsd_pkg;

  localparam int unsigned WINDOW_MAX_DEF   = 64;
  localparam int unsigned SAMPLE_WIDTH_DEF = 32;

  localparam int unsigned OUT_W      = 32;
  localparam int unsigned WL_W       = 7;
  localparam int unsigned SCALE_W    = 16;
  localparam int unsigned SCALE_FRAC = 8;

  localparam logic [WL_W-1:0]    WL_RESET    = 7'd20;
  localparam logic [SCALE_W-1:0] SCALE_RESET = 16'd512;

  localparam int unsigned APB_ADDR_W = 3;
  localparam int unsigned APB_DATA_W = 32;

  // quotient bits resolved per divider cycle
  localparam int unsigned DIV_RADIX_BITS = 4;

  typedef struct packed {
    logic busy;
    logic done;
  } unit_status_t;

endpackage

`default_nettype wire

// ----- src/rwsd_window_mem.sv -----
// Window sample store: one write port, one read port, registered read data.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

module rwsd_window_mem #(
  parameter int unsigned DEPTH  = 64,
  parameter int unsigned WIDTH  = 32,
  parameter int unsigned ADDR_W = 6
) (
  input  wire logic              clk_i,
  input  wire logic              we_i,
  input  wire logic [ADDR_W-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]  wdata_i,
  input  wire logic              re_i,
  input  wire logic [ADDR_W-1:0] raddr_i,
  output logic      [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ----- src/rwsd_divider.sv -----
// Iterative unsigned divider, several quotient bits per cycle, small divisor.
// Depends on rwsd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rwsd_divider import rwsd_pkg::*; #(
  parameter int unsigned DIV_W = 71,
  parameter int unsigned DVS_W = 7
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  input  wire logic [DIV_W-1:0] dividend_i,
  input  wire logic [DVS_W-1:0] divisor_i,
  output logic      [DIV_W-1:0] quotient_o,
  output unit_status_t          status_o
);

  localparam int unsigned STEPS = (DIV_W + DIV_RADIX_BITS - 1) / DIV_RADIX_BITS;
  localparam int unsigned PAD_W = STEPS * DIV_RADIX_BITS;
  localparam int unsigned CNT_W = $clog2(STEPS + 1);

  logic             busy_q, done_q;
  logic [CNT_W-1:0] cnt_q;
  logic [PAD_W-1:0] work_q, work_d;
  logic [DVS_W-1:0] rem_q, rem_d;
  logic [DVS_W-1:0] dvs_q;

  always_comb begin
    logic [DVS_W:0] trial;
    work_d = work_q;
    rem_d  = rem_q;
    for (int i = 0; i < DIV_RADIX_BITS; i++) begin
      trial  = {rem_d, work_d[PAD_W-1]};
      work_d = {work_d[PAD_W-2:0], 1'b0};
      if (trial >= {1'b0, dvs_q}) begin
        rem_d     = DVS_W'(trial - {1'b0, dvs_q});
        work_d[0] = 1'b1;
      end else begin
        rem_d = trial[DVS_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_W'(STEPS);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      work_q <= PAD_W'(dividend_i);
      rem_q  <= '0;
      dvs_q  <= divisor_i;
    end else if (busy_q) begin
      work_q <= work_d;
      rem_q  <= rem_d;
    end
  end

  assign quotient_o = work_q[DIV_W-1:0];
  assign status_o   = '{busy: busy_q, done: done_q};

endmodule

`default_nettype wire

// ----- src/rwsd_sqrt.sv -----
// Digit-by-digit floor square root, one root bit per cycle.
// Depends on rwsd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rwsd_sqrt import rwsd_pkg::*; #(
  parameter int unsigned ROOT_W = 32
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                start_i,
  input  wire logic [2*ROOT_W-1:0] radicand_i,
  output logic      [ROOT_W-1:0]   root_o,
  output unit_status_t             status_o
);

  localparam int unsigned RAD_W = 2 * ROOT_W;
  localparam int unsigned REM_W = ROOT_W + 2;
  localparam int unsigned T_W   = ROOT_W + 4;
  localparam int unsigned CNT_W = $clog2(ROOT_W + 1);

  logic              busy_q, done_q;
  logic [CNT_W-1:0]  cnt_q;
  logic [RAD_W-1:0]  rad_q;
  logic [REM_W-1:0]  rem_q, rem_d;
  logic [ROOT_W-1:0] root_q, root_d;
  logic [T_W-1:0]    t, trial;

  always_comb begin
    t     = {rem_q, rad_q[RAD_W-1:RAD_W-2]};
    trial = T_W'({root_q, 2'b01});
    if (t >= trial) begin
      rem_d  = REM_W'(t - trial);
      root_d = {root_q[ROOT_W-2:0], 1'b1};
    end else begin
      rem_d  = t[REM_W-1:0];
      root_d = {root_q[ROOT_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_W'(ROOT_W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rad_q  <= radicand_i;
      rem_q  <= '0;
      root_q <= '0;
    end else if (busy_q) begin
      rad_q  <= rad_q << 2;
      rem_q  <= rem_d;
      root_q <= root_d;
    end
  end

  assign root_o   = root_q;
  assign status_o = '{busy: busy_q, done: done_q};

endmodule

`default_nettype wire

// ----- src/rolling_window_std_deviation.sv -----
// Moving standard deviation over the last window_length samples.
// Each result takes two memory passes, two divider runs and the square root between
// input transfer and out_valid_o. Throughput: one sample in flight; the next is taken
// from the cycle the result is presented, which waits while an earlier result is pending;
// a sample that does not yet fill the window is stored with no result, staying ready.
// Reset clears control, fill count and write position; registers reset to 20 / 512.
`timescale 1ns / 1ps
`default_nettype none

module rolling_window_std_deviation import rwsd_pkg::*; #(
  parameter int unsigned WINDOW_MAX   = WINDOW_MAX_DEF,
  parameter int unsigned SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    psel,
  input  wire logic                    penable,
  input  wire logic                    pwrite,
  input  wire logic [APB_ADDR_W-1:0]   paddr,
  input  wire logic [APB_DATA_W-1:0]   pwdata,
  output logic      [APB_DATA_W-1:0]   prdata,
  output logic                         pready,
  input  wire logic                    in_valid_i,
  output logic                         in_ready_o,
  input  wire logic [SAMPLE_WIDTH-1:0] sample_value_i,
  input  wire logic                    first_of_series_i,
  output logic                         out_valid_o,
  input  wire logic                    out_ready_i,
  output logic      [OUT_W-1:0]        deviation_value_o
);

  localparam int unsigned S      = SAMPLE_WIDTH;
  localparam int unsigned ADDR_W = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
  localparam int unsigned CNT_W  = $clog2(WINDOW_MAX + 1);
  localparam int unsigned LC_W   = (CNT_W > WL_W) ? CNT_W : WL_W;
  localparam int unsigned SUM_W  = S + CNT_W;
  localparam int unsigned SQ_W   = 2 * S;
  localparam int unsigned ACC_W  = SQ_W + CNT_W;
  localparam int unsigned LO_W   = (S + 1) / 2;
  localparam int unsigned HI_W   = S - LO_W;
  localparam int unsigned PROD_W = S + SCALE_W;
  localparam int unsigned SC_W   = PROD_W - SCALE_FRAC;
  localparam int unsigned SCX_W  = (SC_W > OUT_W) ? SC_W : OUT_W + 1;

  localparam logic REG_WINDOW_LENGTH = 1'b0;
  localparam logic REG_DEV_SCALE     = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SUM,
    ST_DIV_MEAN,
    ST_DEV,
    ST_DIV_VAR,
    ST_SQRT,
    ST_OUT
  } state_e;

  // configuration
  logic [WL_W-1:0]    wl_q;
  logic [SCALE_W-1:0] scale_q;
  logic               cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wl_q    <= WL_RESET;
      scale_q <= SCALE_RESET;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        REG_WINDOW_LENGTH: wl_q    <= pwdata[WL_W-1:0];
        REG_DEV_SCALE:     scale_q <= pwdata[SCALE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_WINDOW_LENGTH: prdata = APB_DATA_W'(wl_q);
      REG_DEV_SCALE:     prdata = APB_DATA_W'(scale_q);
      default:           prdata = '0;
    endcase
  end

  // control state
  state_e            state_q, state_d;
  logic [ADDR_W-1:0] wp_q, wp_d;
  logic [CNT_W-1:0]  fill_q, fill_d;
  logic [CNT_W-1:0]  iss_q, iss_d;
  logic [ADDR_W-1:0] raddr_q, raddr_d;
  logic              rd_vld_q, mag_vld_q, pp_vld_q, sq_vld_q;
  logic              mag_vld_d;
  logic              out_valid_q, out_valid_d;

  // datapath
  logic [CNT_W-1:0]    len_q;
  logic [ADDR_W-1:0]   newest_q;
  logic [SUM_W-1:0]    sum_q;
  logic [S-1:0]        mean_q;
  logic [S-1:0]        mag_q;
  logic [2*HI_W-1:0]   aa_q;
  logic [HI_W+LO_W-1:0] ab_q;
  logic [2*LO_W-1:0]   bb_q;
  logic [SQ_W-1:0]     sq_q;
  logic [ACC_W-1:0]    acc_q;
  logic [PROD_W-1:0]   prod_q;
  logic [OUT_W-1:0]    dev_q;

  logic              in_acc, out_free, mem_re, div_start, sqrt_start;
  logic [ADDR_W-1:0] wp_eff, wp_next, raddr_dec;
  logic [CNT_W-1:0]  fill_eff, fill_next, len_new;
  logic [LC_W-1:0]   wl_x;
  logic [S-1:0]      rdata;
  logic [S:0]        diff;
  logic [S-1:0]      mag_d;
  logic [SUM_W-1:0]  sum_mag;
  logic [ACC_W-1:0]  div_dividend, div_quot;
  logic [S-1:0]      mean_mag, root;
  logic [SCX_W-1:0]  scx;
  logic [OUT_W-1:0]  sat_val;
  unit_status_t      div_st, sqrt_st;

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_acc     = in_valid_i & in_ready_o;
  assign out_free   = ~out_valid_q | out_ready_i;

  assign wp_eff    = first_of_series_i ? '0 : wp_q;
  assign wp_next   = (wp_eff == ADDR_W'(WINDOW_MAX - 1)) ? '0 : wp_eff + 1'b1;
  assign fill_eff  = first_of_series_i ? '0 : fill_q;
  assign fill_next = (fill_eff == CNT_W'(WINDOW_MAX)) ? fill_eff : fill_eff + 1'b1;
  assign raddr_dec = (raddr_q == '0) ? ADDR_W'(WINDOW_MAX - 1) : raddr_q - 1'b1;

  assign wl_x = LC_W'(wl_q);
  always_comb begin
    if (wl_x == '0) begin
      len_new = CNT_W'(1);
    end else if (wl_x > LC_W'(WINDOW_MAX)) begin
      len_new = CNT_W'(WINDOW_MAX);
    end else begin
      len_new = CNT_W'(wl_x);
    end
  end

  always_comb begin
    state_d     = state_q;
    wp_d        = wp_q;
    fill_d      = fill_q;
    iss_d       = iss_q;
    raddr_d     = raddr_q;
    out_valid_d = out_valid_q & ~out_ready_i;
    mem_re      = 1'b0;
    div_start   = 1'b0;
    sqrt_start  = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          wp_d   = wp_next;
          fill_d = fill_next;
          if (fill_next >= len_new) begin
            state_d = ST_SUM;
            iss_d   = len_new;
            raddr_d = wp_eff;
          end
        end
      end
      ST_SUM: begin
        if (iss_q != '0) begin
          mem_re  = 1'b1;
          iss_d   = iss_q - 1'b1;
          raddr_d = raddr_dec;
        end else if (!rd_vld_q) begin
          div_start = 1'b1;
          state_d   = ST_DIV_MEAN;
        end
      end
      ST_DIV_MEAN: begin
        if (div_st.done) begin
          state_d = ST_DEV;
          iss_d   = len_q;
          raddr_d = newest_q;
        end
      end
      ST_DEV: begin
        if (iss_q != '0) begin
          mem_re  = 1'b1;
          iss_d   = iss_q - 1'b1;
          raddr_d = raddr_dec;
        end else if (!(rd_vld_q | mag_vld_q | pp_vld_q | sq_vld_q)) begin
          div_start = 1'b1;
          state_d   = ST_DIV_VAR;
        end
      end
      ST_DIV_VAR: begin
        if (div_st.done) begin
          sqrt_start = 1'b1;
          state_d    = ST_SQRT;
        end
      end
      ST_SQRT: begin
        if (sqrt_st.done) begin
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign mag_vld_d = rd_vld_q & (state_q == ST_DEV);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      wp_q        <= '0;
      fill_q      <= '0;
      iss_q       <= '0;
      raddr_q     <= '0;
      rd_vld_q    <= 1'b0;
      mag_vld_q   <= 1'b0;
      pp_vld_q    <= 1'b0;
      sq_vld_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      wp_q        <= wp_d;
      fill_q      <= fill_d;
      iss_q       <= iss_d;
      raddr_q     <= raddr_d;
      rd_vld_q    <= mem_re;
      mag_vld_q   <= mag_vld_d;
      pp_vld_q    <= mag_vld_q;
      sq_vld_q    <= pp_vld_q;
      out_valid_q <= out_valid_d;
    end
  end

  rwsd_window_mem #(
    .DEPTH  (WINDOW_MAX),
    .WIDTH  (S),
    .ADDR_W (ADDR_W)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (in_acc),
    .waddr_i (wp_eff),
    .wdata_i (sample_value_i),
    .re_i    (mem_re),
    .raddr_i (raddr_q),
    .rdata_o (rdata)
  );

  assign sum_mag      = sum_q[SUM_W-1] ? SUM_W'(-sum_q) : sum_q;
  assign div_dividend = (state_q == ST_SUM) ? ACC_W'(sum_mag) : acc_q;

  rwsd_divider #(
    .DIV_W (ACC_W),
    .DVS_W (CNT_W)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (len_q),
    .quotient_o (div_quot),
    .status_o   (div_st)
  );

  rwsd_sqrt #(
    .ROOT_W (S)
  ) u_sqrt (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (sqrt_start),
    .radicand_i (div_quot[SQ_W-1:0]),
    .root_o     (root),
    .status_o   (sqrt_st)
  );

  assign mean_mag = div_quot[S-1:0];
  assign diff     = {rdata[S-1], rdata} - {mean_q[S-1], mean_q};
  assign mag_d    = diff[S] ? S'(-diff) : diff[S-1:0];

  assign scx     = SCX_W'(prod_q >> SCALE_FRAC);
  assign sat_val = ((scx >> OUT_W) != '0) ? '1 : scx[OUT_W-1:0];

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      len_q    <= len_new;
      newest_q <= wp_eff;
      sum_q    <= '0;
    end
    if (state_q == ST_SUM && rd_vld_q) begin
      sum_q <= sum_q + {{(SUM_W - S){rdata[S-1]}}, rdata};
    end
    if (state_q == ST_DIV_MEAN && div_st.done) begin
      mean_q <= sum_q[SUM_W-1] ? S'(-mean_mag) : mean_mag;
      acc_q  <= '0;
    end
    // squaring split into half-width partial products
    mag_q <= mag_d;
    aa_q  <= (2*HI_W)'(mag_q[S-1:LO_W]) * (2*HI_W)'(mag_q[S-1:LO_W]);
    ab_q  <= (HI_W+LO_W)'(mag_q[S-1:LO_W]) * (HI_W+LO_W)'(mag_q[LO_W-1:0]);
    bb_q  <= (2*LO_W)'(mag_q[LO_W-1:0]) * (2*LO_W)'(mag_q[LO_W-1:0]);
    sq_q  <= (SQ_W'(aa_q) << (2*LO_W)) + (SQ_W'(ab_q) << (LO_W + 1)) + SQ_W'(bb_q);
    if (sq_vld_q) begin
      acc_q <= acc_q + ACC_W'(sq_q);
    end
    if (state_q == ST_SQRT && sqrt_st.done) begin
      prod_q <= PROD_W'(root) * PROD_W'(scale_q);
    end
    if (state_q == ST_OUT && out_free) begin
      dev_q <= sat_val;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign deviation_value_o = dev_q;

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= CNT_W'(WINDOW_MAX))
    else $error("fill count above window depth");

  a_div_running: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV_MEAN || state_q == ST_DIV_VAR) |-> (div_st.busy || div_st.done))
    else $error("waiting on divider that is not running");

  a_sqrt_running: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SQRT) |-> (sqrt_st.busy || sqrt_st.done))
    else $error("waiting on square root unit that is not running");

  a_out_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_OUT && out_valid_q && !out_ready_i) |=> (state_q == ST_OUT))
    else $error("result dropped over pending transfer");

endmodule

`default_nettype wire
